// ----- sv/fzl_pkg.sv -----
// ----------------------------------------------------------------------------
// fzl_pkg
// Shared types, constants and functions of the fuzzy leak classifier.
// ----------------------------------------------------------------------------
package fzl_pkg;

   localparam int ReadingW = 16;
   localparam int GradeW   = 9;
   localparam int DenW     = 10;
   localparam int ProdW    = 26;
   localparam int SumW     = 28;
   localparam int MagW     = 25;
   localparam int QuoW     = 16;
   localparam int DivSteps = 4;
   localparam int DivBitsPerStep = QuoW / DivSteps;

   localparam int GradeOne = 256;

   typedef logic [GradeW-1:0] grade_type;

   typedef enum logic [1:0] {
      CSR_CENTER_LOW  = 2'd0,
      CSR_CENTER_MID  = 2'd1,
      CSR_CENTER_HIGH = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic             valid;
      logic [DenW-1:0]  rem;
      logic [QuoW-1:0]  low;
      logic [DenW-1:0]  den;
      logic             neg;
      logic             zero;
   } div_stage_type;

   // Membership grade of a trapezoid; a triangle has p1 equal to p2. All slopes
   // are powers of two, so every ramp is a left shift.
   function automatic grade_type trap_grade(logic signed [ReadingW-1:0] x,
                                            int p0, int p1, int p2, int p3,
                                            int su, int sd);
      logic signed [ReadingW+1:0] xe;
      logic signed [ReadingW+1:0] d;
      grade_type                  g;
      xe = (ReadingW+2)'(x);
      d  = '0;
      if (xe <= (ReadingW+2)'(p0)) begin
         g = '0;
      end else if (xe <= (ReadingW+2)'(p1)) begin
         d = (xe - (ReadingW+2)'(p0)) <<< su;
         g = d[GradeW-1:0];
      end else if (xe <= (ReadingW+2)'(p2)) begin
         g = GradeW'(GradeOne);
      end else if (xe <= (ReadingW+2)'(p3)) begin
         d = ((ReadingW+2)'(p3) - xe) <<< sd;
         g = d[GradeW-1:0];
      end else begin
         g = '0;
      end
      return g;
   endfunction

   function automatic grade_type min_grade(grade_type a, grade_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic grade_type max_grade(grade_type a, grade_type b);
      return (a > b) ? a : b;
   endfunction

   // Several restoring division steps: one quotient bit per step.
   function automatic div_stage_type div_step(div_stage_type s);
      div_stage_type  r;
      logic [DenW:0]  t;
      r = s;
      for (int i = 0; i < DivBitsPerStep; i++) begin
         t = {r.rem, r.low[QuoW-1]};
         r.low = {r.low[QuoW-2:0], 1'b0};
         if (t >= {1'b0, r.den}) begin
            t = t - {1'b0, r.den};
            r.low[0] = 1'b1;
         end
         r.rem = t[DenW-1:0];
      end
      return r;
   endfunction

endpackage

// ----- sv/fzl_div.sv -----
// ----------------------------------------------------------------------------
// fzl_div
// Pipelined unsigned divider: magnitude of the weighted sum by the strength sum.
// ----------------------------------------------------------------------------
module fzl_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  fzl_pkg::div_stage_type      in_stage,
   output fzl_pkg::div_stage_type      out_stage
);
   import fzl_pkg::*;

   div_stage_type stage_ff [DivSteps];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DivSteps; i++) begin
            stage_ff[i].valid <= 1'b0;
         end
      end else if (advance) begin
         stage_ff[0] <= div_step(in_stage);
         for (int i = 1; i < DivSteps; i++) begin
            stage_ff[i] <= div_step(stage_ff[i-1]);
         end
      end
   end

   assign out_stage = stage_ff[DivSteps-1];

endmodule

// ----- sv/fuzzy_leak_classifier.sv -----
// ----------------------------------------------------------------------------
// fuzzy_leak_classifier
// Two-input fuzzy classifier with min/max inference and weighted average.
// ----------------------------------------------------------------------------
// A request is taken in every cycle in which the result side does not stall;
// each request produces one response. The path runs through the grading, rule,
// multiply and sum stages, then a four-stage divider that resolves four
// quotient bits per stage, and last the output register.
module fuzzy_leak_classifier (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [fzl_pkg::ReadingW-1:0] req_reading_a,
   input  logic signed [fzl_pkg::ReadingW-1:0] req_reading_b,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [fzl_pkg::ReadingW-1:0] rsp_crisp_value,
   output logic                               rsp_no_rule_fired,
   input  logic                               csr_write,
   input  logic [1:0]                         csr_index,
   input  logic [fzl_pkg::ReadingW-1:0]       csr_data
);
   import fzl_pkg::*;

   logic                       advance;
   logic signed [ReadingW-1:0] center_ff [3];

   logic                       v1_ff, v2_ff, v3_ff, v4_ff;
   grade_type                  a_ff [3];
   grade_type                  b_ff [3];
   grade_type                  s_ff [3];
   logic signed [ProdW-1:0]    p_ff [3];
   logic [DenW-1:0]            den3_ff;
   logic [MagW-1:0]            mag_ff;
   logic [DenW-1:0]            den4_ff;
   logic                       neg_ff;
   logic                       zero_ff;

   logic signed [SumW-1:0]     sum_in;
   logic [SumW-1:0]            mag_in;
   grade_type                  bmax;
   div_stage_type              div_in;
   div_stage_type              div_out;
   logic signed [ReadingW-1:0] value_in;

   logic                       rsp_valid_ff;
   logic signed [ReadingW-1:0] rsp_value_ff;
   logic                       rsp_flag_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff[0] <= 16'sd32;
         center_ff[1] <= 16'sd48;
         center_ff[2] <= 16'sd64;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_CENTER_LOW:  center_ff[0] <= csr_data;
            CSR_CENTER_MID:  center_ff[1] <= csr_data;
            CSR_CENTER_HIGH: center_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   assign bmax   = max_grade(max_grade(b_ff[0], b_ff[1]), b_ff[2]);
   assign sum_in = SumW'(p_ff[0]) + SumW'(p_ff[1]) + SumW'(p_ff[2]);
   assign mag_in = sum_in[SumW-1] ? SumW'(-sum_in) : SumW'(sum_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
         a_ff[0] <= trap_grade(req_reading_a, -96, -32, 0, 32, 2, 3);
         a_ff[1] <= trap_grade(req_reading_a, 0, 32, 32, 64, 3, 3);
         a_ff[2] <= trap_grade(req_reading_a, 32, 64, 96, 128, 3, 3);
         b_ff[0] <= trap_grade(req_reading_b, -96, -96, 8, 16, 5, 5);
         b_ff[1] <= trap_grade(req_reading_b, 8, 16, 16, 24, 5, 5);
         b_ff[2] <= trap_grade(req_reading_b, 16, 24, 32, 40, 5, 5);

         v2_ff <= v1_ff;
         for (int i = 0; i < 3; i++) begin
            s_ff[i] <= min_grade(a_ff[i], bmax);
         end

         v3_ff <= v2_ff;
         for (int i = 0; i < 3; i++) begin
            p_ff[i] <= ProdW'($signed({1'b0, s_ff[i]}) * center_ff[i]);
         end
         den3_ff <= DenW'(s_ff[0]) + DenW'(s_ff[1]) + DenW'(s_ff[2]);

         v4_ff   <= v3_ff;
         mag_ff  <= mag_in[MagW-1:0];
         neg_ff  <= sum_in[SumW-1];
         den4_ff <= den3_ff;
         zero_ff <= (den3_ff == '0);
      end
   end

   always_comb begin
      div_in.valid = v4_ff;
      div_in.rem   = DenW'(mag_ff[MagW-1:QuoW]);
      div_in.low   = mag_ff[QuoW-1:0];
      div_in.den   = den4_ff;
      div_in.neg   = neg_ff;
      div_in.zero  = zero_ff;
   end

   fzl_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_stage  (div_in),
      .out_stage (div_out)
   );

   always_comb begin
      if (div_out.zero) begin
         value_in = '0;
      end else if (div_out.neg) begin
         value_in = ReadingW'(-$signed({1'b0, div_out.low}));
      end else if (div_out.low[QuoW-1]) begin
         value_in = 16'sd32767;
      end else begin
         value_in = $signed(div_out.low);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= div_out.valid;
         rsp_value_ff <= value_in;
         rsp_flag_ff  <= div_out.zero;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_crisp_value   = rsp_value_ff;
   assign rsp_no_rule_fired = rsp_flag_ff;

endmodule
